/* hdl/lsae_pkg.sv */
package lsae_pkg;

  // request codes
  localparam logic [4:0] OP_LDB   = 5'd0;
  localparam logic [4:0] OP_LDBU  = 5'd1;
  localparam logic [4:0] OP_LDW   = 5'd2;
  localparam logic [4:0] OP_LDWU  = 5'd3;
  localparam logic [4:0] OP_LDT   = 5'd4;
  localparam logic [4:0] OP_LDTU  = 5'd5;
  localparam logic [4:0] OP_LDO   = 5'd6;
  localparam logic [4:0] OP_LDOU  = 5'd7;
  localparam logic [4:0] OP_LDHT  = 5'd8;
  localparam logic [4:0] OP_STB   = 5'd9;
  localparam logic [4:0] OP_STBU  = 5'd10;
  localparam logic [4:0] OP_STW   = 5'd11;
  localparam logic [4:0] OP_STWU  = 5'd12;
  localparam logic [4:0] OP_STT   = 5'd13;
  localparam logic [4:0] OP_STTU  = 5'd14;
  localparam logic [4:0] OP_STO   = 5'd15;
  localparam logic [4:0] OP_STOU  = 5'd16;
  localparam logic [4:0] OP_STHT  = 5'd17;
  localparam logic [4:0] OP_STCO  = 5'd18;
  localparam logic [4:0] OP_SETH  = 5'd19;
  localparam logic [4:0] OP_SETMH = 5'd20;
  localparam logic [4:0] OP_SETML = 5'd21;
  localparam logic [4:0] OP_SETL  = 5'd22;

  // access kind after folding stores onto loads
  localparam logic [3:0] KIND_HT = 4'd8;

  // access size codes
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_WYDE  = 2'd1;
  localparam logic [1:0] SZ_TETRA = 2'd2;
  localparam logic [1:0] SZ_OCTA  = 2'd3;

  // immediate placement for the set operations
  localparam int SHIFT_HIGH_TETRA   = 32;
  localparam int SHIFT_HIGH_WYDE    = 48;
  localparam int SHIFT_LOW_MID_WYDE = 16;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [63:0] base_addr;
    logic [63:0] offset;
    logic [63:0] source_value;
    logic [7:0]  const_byte;
    logic [15:0] wide_immediate;
    logic [63:0] mem_word;
  } req_t;

  typedef struct packed {
    logic [63:0] reg_value;
    logic        reg_write;
    logic [63:0] mem_addr;
    logic [63:0] store_data;
    logic [7:0]  byte_enable;
    logic        mem_write;
    logic        overflow;
  } res_t;

endpackage

/* hdl/lsae_datapath.sv */
module lsae_datapath import lsae_pkg::*; (
  input  req_t req,
  output res_t res
);

  logic [63:0] ea;
  logic [3:0]  kind;
  logic [1:0]  sz;
  logic [3:0]  nbytes;
  logic [2:0]  lane;
  logic [2:0]  shb;
  logic [5:0]  shbits;
  logic [63:0] mask;
  logic [7:0]  lane_mask;
  logic [63:0] picked;
  logic [63:0] ld_value;
  logic [63:0] st_src;
  logic        is_signed;
  logic        fits;

  // effective address and access geometry
  always_comb begin
    ea     = req.base_addr + req.offset;
    kind   = (req.req_type <= OP_LDHT) ? req.req_type[3:0] : 4'(req.req_type - OP_STB);
    sz     = (kind == KIND_HT) ? SZ_TETRA : kind[2:1];
    nbytes = 4'd1 << sz;
    lane   = ea[2:0] & ~(nbytes[2:0] - 3'd1);
    shb    = 3'(4'd8 - {1'b0, lane} - nbytes);
    shbits = {shb, 3'b000};
    is_signed = (kind[0] == 1'b0) && (kind != KIND_HT);
  end

  // size masks and range check
  always_comb begin
    unique case (sz)
      SZ_BYTE: begin
        mask      = 64'h0000_0000_0000_00FF;
        lane_mask = 8'h01;
        fits      = (&req.source_value[63:7]) | ~(|req.source_value[63:7]);
      end
      SZ_WYDE: begin
        mask      = 64'h0000_0000_0000_FFFF;
        lane_mask = 8'h03;
        fits      = (&req.source_value[63:15]) | ~(|req.source_value[63:15]);
      end
      SZ_TETRA: begin
        mask      = 64'h0000_0000_FFFF_FFFF;
        lane_mask = 8'h0F;
        fits      = (&req.source_value[63:31]) | ~(|req.source_value[63:31]);
      end
      default: begin
        mask      = 64'hFFFF_FFFF_FFFF_FFFF;
        lane_mask = 8'hFF;
        fits      = 1'b1;
      end
    endcase
  end

  // load extraction and extension
  always_comb begin
    picked = (req.mem_word >> shbits) & mask;
    if (kind == KIND_HT) begin
      ld_value = picked << SHIFT_HIGH_TETRA;
    end else if (is_signed) begin
      unique case (sz)
        SZ_BYTE:  ld_value = {{56{picked[7]}}, picked[7:0]};
        SZ_WYDE:  ld_value = {{48{picked[15]}}, picked[15:0]};
        SZ_TETRA: ld_value = {{32{picked[31]}}, picked[31:0]};
        default:  ld_value = picked;
      endcase
    end else begin
      ld_value = picked;
    end
    st_src = (kind == KIND_HT) ? (req.source_value >> SHIFT_HIGH_TETRA) : req.source_value;
  end

  // result word by request class
  always_comb begin
    res = '0;
    priority if (req.req_type <= OP_LDHT) begin
      res.mem_addr  = {ea[63:3], 3'b000};
      res.reg_value = ld_value;
      res.reg_write = 1'b1;
    end else if (req.req_type <= OP_STHT) begin
      res.mem_addr    = {ea[63:3], 3'b000};
      res.store_data  = (st_src & mask) << shbits;
      res.byte_enable = lane_mask << shb;
      res.mem_write   = 1'b1;
      res.overflow    = is_signed & ~fits;
    end else if (req.req_type == OP_STCO) begin
      res.mem_addr    = {ea[63:3], 3'b000};
      res.store_data  = {56'd0, req.const_byte};
      res.byte_enable = 8'hFF;
      res.mem_write   = 1'b1;
    end else if (req.req_type == OP_SETH) begin
      res.reg_value = {req.wide_immediate, 48'd0};
      res.reg_write = 1'b1;
    end else if (req.req_type == OP_SETMH) begin
      res.reg_value = {16'd0, req.wide_immediate, 32'd0};
      res.reg_write = 1'b1;
    end else if (req.req_type == OP_SETML) begin
      res.reg_value = {32'd0, req.wide_immediate, 16'd0};
      res.reg_write = 1'b1;
    end else if (req.req_type == OP_SETL) begin
      res.reg_value = {48'd0, req.wide_immediate};
      res.reg_write = 1'b1;
    end else begin
      res = '0;
    end
  end

endmodule

/* hdl/load_store_align_extend_unit.sv */
// Load/store lane logic for a 64-bit big-endian data path.
// Input channel: a request word is taken at a rising edge where start is
// high and busy is low. busy is held low, so a request can be issued in
// every cycle. The request carries the opcode, base and offset, the store
// source, the store constant, the set immediate and the fetched octabyte.
// Result channel: each request yields one result word, shown on the out_
// ports for exactly one cycle while out_valid is high. The receiver has no
// way to stall; it must take the word in that cycle.
// Path: the accepted word passes the input register, then the address
// adder and lane muxes, then the result register (one input register, one
// result register). Throughput is one word per cycle, set by the single
// pass of the address adder and lane muxes between the two registers.
// Reset (rst_n low, synchronous) drops any word in flight and clears
// out_valid; payload registers are not cleared.
module load_store_align_extend_unit import lsae_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_req_type,
  input  logic [63:0] in_base_addr,
  input  logic [63:0] in_offset,
  input  logic [63:0] in_source_value,
  input  logic [7:0]  in_const_byte,
  input  logic [15:0] in_wide_immediate,
  input  logic [63:0] in_mem_word,
  output logic        out_valid,
  output logic [63:0] out_reg_value,
  output logic        out_reg_write,
  output logic [63:0] out_mem_addr,
  output logic [63:0] out_store_data,
  output logic [7:0]  out_byte_enable,
  output logic        out_mem_write,
  output logic        out_overflow
);

  req_t req_r;
  logic req_vld_r;
  res_t res_nxt;
  res_t res_r;
  logic out_valid_r;

  // every cycle is open for a new word
  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start & ~busy;
    end
    if (start & ~busy) begin
      req_r.req_type       <= in_req_type;
      req_r.base_addr      <= in_base_addr;
      req_r.offset         <= in_offset;
      req_r.source_value   <= in_source_value;
      req_r.const_byte     <= in_const_byte;
      req_r.wide_immediate <= in_wide_immediate;
      req_r.mem_word       <= in_mem_word;
    end
  end

  // address, alignment and lane logic
  lsae_datapath u_datapath (
    .req (req_r),
    .res (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_vld_r;
    end
    if (req_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reg_value   = res_r.reg_value;
  assign out_reg_write   = res_r.reg_write;
  assign out_mem_addr    = res_r.mem_addr;
  assign out_store_data  = res_r.store_data;
  assign out_byte_enable = res_r.byte_enable;
  assign out_mem_write   = res_r.mem_write;
  assign out_overflow    = res_r.overflow;

`ifndef SYNTHESIS
  // a result word always follows an accepted request
  a_valid_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req_vld_r))
    else $error("result word without a request");

  // overflow only on stores
  a_ovf_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> out_mem_write)
    else $error("overflow flagged on a non-store");

  // register write and memory write never together
  a_rw_mw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_reg_write && out_mem_write))
    else $error("register and memory write in one word");

  // non-stores drive no lanes
  a_no_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_mem_write) |-> (out_byte_enable == 8'h00 && out_store_data == 64'd0))
    else $error("lanes driven without a store");
`endif

endmodule
